>>> sv/qalu_pkg.sv
`default_nettype none
package qalu_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int T_W       = PROD_W + 2 - FRAC_W;
  localparam int TL_W      = T_W / 2;
  localparam int TH_W      = T_W - TL_W;
  localparam int TP_W      = WORD_W + T_W;
  localparam int ACC_W     = TP_W + 4;
  localparam int NORM_W    = PROD_W + 1;
  localparam int DIV_W     = PROD_W + 2;
  localparam int REM_W     = DIV_W + 1;
  localparam int ROT_LAT   = 3;
  localparam int DIV_LAT   = WORD_W + 2;
  localparam int ALIGN_LEN = DIV_LAT - ROT_LAT;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_MUL = 2'd0;
  localparam mode_t MODE_ROT = 2'd1;
  localparam mode_t MODE_INV = 2'd2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [T_W-1:0]    tword_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef struct packed {
    word_t w;
    word_t x;
    word_t y;
    word_t z;
    logic  zero_norm;
    logic  saturated;
  } res_t;

  typedef struct packed {
    word_t val;
    logic  sat;
  } satw_t;

  typedef struct packed {
    logic               vld;
    mode_t              mode;
    word_t [3:0]        a;
    word_t [2:0]        v;
    res_t               mres;
    tword_t [2:0]       t;
    logic [NORM_W-1:0]  norm;
  } prod_t;

  function automatic acc_t rnd(input acc_t v);
    rnd = (v + (acc_t'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
  endfunction

  function automatic satw_t sat_word(input acc_t v);
    satw_t s;
    acc_t  hi;
    acc_t  lo;
    hi = acc_t'(WORD_MAX);
    lo = acc_t'(WORD_MIN);
    if (v > hi) begin
      s.val = WORD_MAX;
      s.sat = 1'b1;
    end else if (v < lo) begin
      s.val = WORD_MIN;
      s.sat = 1'b1;
    end else begin
      s.val = v[WORD_W-1:0];
      s.sat = 1'b0;
    end
    sat_word = s;
  endfunction

endpackage
`default_nettype wire

>>> sv/quaternion_alu_core.sv
// Results: out_valid marks each result, one result per item taken on start.
// Throughput: one item per cycle; busy is never raised and the result strobe cannot be held.
// Latency is set by the 32-stage restoring divider of the inverse; multiply and rotate
// results are delayed to match so results leave in order.
// Reset: synchronous, active low rst_n clears every valid bit; data registers are not reset.
`default_nettype none
module quaternion_alu_core import qalu_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  output logic       busy,
  input  wire mode_t in_mode,
  input  wire word_t in_a_w,
  input  wire word_t in_a_x,
  input  wire word_t in_a_y,
  input  wire word_t in_a_z,
  input  wire word_t in_b_w,
  input  wire word_t in_b_x,
  input  wire word_t in_b_y,
  input  wire word_t in_b_z,
  output logic       out_valid,
  output word_t      out_r_w,
  output word_t      out_r_x,
  output word_t      out_r_y,
  output word_t      out_r_z,
  output logic       out_zero_norm,
  output logic       out_saturated
);

  word_t a_in [4];
  word_t b_in [4];
  logic  in_fire;
  prod_t prod;
  logic  rot_vld;
  mode_t rot_mode;
  res_t  rot_res;
  logic  div_vld;
  res_t  div_res;

  logic  dvld_r [ALIGN_LEN];
  mode_t dmode_r [ALIGN_LEN];
  res_t  dres_r [ALIGN_LEN];

  logic  out_valid_r;
  res_t  out_res_r;
  res_t  out_res_nxt;

  assign busy    = 1'b0;
  assign in_fire = start & ~busy;

  assign a_in[0] = in_a_w;
  assign a_in[1] = in_a_x;
  assign a_in[2] = in_a_y;
  assign a_in[3] = in_a_z;
  assign b_in[0] = in_b_w;
  assign b_in[1] = in_b_x;
  assign b_in[2] = in_b_y;
  assign b_in[3] = in_b_z;

  qalu_prod u_prod (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_fire),
    .in_mode (in_mode),
    .in_a    (a_in),
    .in_b    (b_in),
    .prod_o  (prod)
  );

  qalu_rot u_rot (
    .clk    (clk),
    .rst_n  (rst_n),
    .prod_i (prod),
    .vld_o  (rot_vld),
    .mode_o (rot_mode),
    .res_o  (rot_res)
  );

  qalu_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .prod_i (prod),
    .vld_o  (div_vld),
    .res_o  (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALIGN_LEN; i++) begin
        dvld_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      dvld_r[0] <= rot_vld;
      for (int i = 1; i < ALIGN_LEN; i++) begin
        dvld_r[i] <= dvld_r[i-1];
      end
      out_valid_r <= dvld_r[ALIGN_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    dmode_r[0] <= rot_mode;
    dres_r[0]  <= rot_res;
    for (int i = 1; i < ALIGN_LEN; i++) begin
      dmode_r[i] <= dmode_r[i-1];
      dres_r[i]  <= dres_r[i-1];
    end
    out_res_r <= out_res_nxt;
  end

  assign out_res_nxt = (dmode_r[ALIGN_LEN-1] == MODE_INV) ? div_res : dres_r[ALIGN_LEN-1];

  assign out_valid     = out_valid_r;
  assign out_r_w       = out_res_r.w;
  assign out_r_x       = out_res_r.x;
  assign out_r_y       = out_res_r.y;
  assign out_r_z       = out_res_r.z;
  assign out_zero_norm = out_res_r.zero_norm;
  assign out_saturated = out_res_r.saturated;

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    dvld_r[ALIGN_LEN-1] == div_vld)
    else $error("divider and vector lanes out of step");

  a_zero_norm_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_norm |-> out_r_w == '0 && out_r_x == '0 && out_r_y == '0
      && out_r_z == '0 && !out_saturated)
    else $error("zero-norm result not cleared");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_r_w == WORD_MAX || out_r_w == WORD_MIN || out_r_x == WORD_MAX
      || out_r_x == WORD_MIN || out_r_y == WORD_MAX || out_r_y == WORD_MIN
      || out_r_z == WORD_MAX || out_r_z == WORD_MIN)
    else $error("saturation flagged with no clamped component");

endmodule
`default_nettype wire

>>> sv/qalu_prod.sv
`default_nettype none
module qalu_prod import qalu_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_vld,
  input  wire mode_t in_mode,
  input  wire word_t in_a [4],
  input  wire word_t in_b [4],
  output prod_t      prod_o
);

  logic                     vld_r;
  mode_t                    mode_r;
  word_t                    a_r [4];
  word_t                    v_r [3];
  logic signed [PROD_W-1:0] pab_r [4][4];
  logic signed [PROD_W-1:0] paa_r [4];
  prod_t                    prod_r;

  acc_t  c [4];
  acc_t  tr [3];
  satw_t ms [4];
  prod_t prod_nxt;

  function automatic acc_t px(input logic signed [PROD_W-1:0] p);
    px = acc_t'(p);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= in_mode;
    for (int i = 0; i < 4; i++) begin
      a_r[i]   <= in_a[i];
      paa_r[i] <= in_a[i] * in_a[i];
      for (int j = 0; j < 4; j++) begin
        pab_r[i][j] <= in_a[i] * in_b[j];
      end
    end
    for (int i = 0; i < 3; i++) begin
      v_r[i] <= in_b[i+1];
    end
  end

  always_comb begin
    c[0] = px(pab_r[0][0]) - px(pab_r[1][1]) - px(pab_r[2][2]) - px(pab_r[3][3]);
    c[1] = px(pab_r[0][1]) + px(pab_r[1][0]) + px(pab_r[2][3]) - px(pab_r[3][2]);
    c[2] = px(pab_r[0][2]) + px(pab_r[2][0]) + px(pab_r[3][1]) - px(pab_r[1][3]);
    c[3] = px(pab_r[0][3]) + px(pab_r[3][0]) + px(pab_r[1][2]) - px(pab_r[2][1]);
    for (int k = 0; k < 4; k++) begin
      ms[k] = sat_word(rnd(c[k]));
    end
    tr[0] = rnd(px(pab_r[2][3]) - px(pab_r[3][2]));
    tr[1] = rnd(px(pab_r[3][1]) - px(pab_r[1][3]));
    tr[2] = rnd(px(pab_r[1][2]) - px(pab_r[2][1]));

    prod_nxt.vld            = vld_r;
    prod_nxt.mode           = mode_r;
    prod_nxt.mres.w         = ms[0].val;
    prod_nxt.mres.x         = ms[1].val;
    prod_nxt.mres.y         = ms[2].val;
    prod_nxt.mres.z         = ms[3].val;
    prod_nxt.mres.zero_norm = 1'b0;
    prod_nxt.mres.saturated = ms[0].sat | ms[1].sat | ms[2].sat | ms[3].sat;
    for (int k = 0; k < 4; k++) begin
      prod_nxt.a[k] = a_r[k];
    end
    for (int k = 0; k < 3; k++) begin
      prod_nxt.v[k] = v_r[k];
      prod_nxt.t[k] = tr[k][T_W-1:0];
    end
    prod_nxt.norm = NORM_W'($unsigned(paa_r[0])) + NORM_W'($unsigned(paa_r[1]))
                  + NORM_W'($unsigned(paa_r[2])) + NORM_W'($unsigned(paa_r[3]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r.vld <= 1'b0;
    end else begin
      prod_r.vld <= prod_nxt.vld;
    end
    prod_r.mode <= prod_nxt.mode;
    prod_r.a    <= prod_nxt.a;
    prod_r.v    <= prod_nxt.v;
    prod_r.mres <= prod_nxt.mres;
    prod_r.t    <= prod_nxt.t;
    prod_r.norm <= prod_nxt.norm;
  end

  assign prod_o = prod_r;

endmodule
`default_nettype wire

>>> sv/qalu_rot.sv
`default_nettype none
module qalu_rot import qalu_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire prod_t prod_i,
  output logic       vld_o,
  output mode_t      mode_o,
  output res_t       res_o
);

  localparam int PL_W  = WORD_W + TL_W + 1;
  localparam int PH_W  = WORD_W + TH_W;
  localparam int NPROD = 9;
  localparam int CA [NPROD] = '{0, 0, 0, 2, 3, 3, 1, 1, 2};
  localparam int CT [NPROD] = '{0, 1, 2, 2, 1, 0, 2, 1, 0};

  typedef logic signed [PL_W-1:0] pl_t;
  typedef logic signed [PH_W-1:0] ph_t;
  typedef logic signed [TP_W-1:0] tp_t;

  typedef struct packed {
    mode_t       mode;
    word_t [2:0] v;
    res_t        mres;
  } side_t;

  pl_t   pl_r [NPROD];
  ph_t   ph_r [NPROD];
  tp_t   full_r [NPROD];
  side_t side_r [2];
  logic  vld_r [3];
  res_t  res_r;
  mode_t mode_r;

  acc_t  s [3];
  satw_t rs [3];
  res_t  res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= prod_i.vld;
      vld_r[1] <= vld_r[0];
      vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NPROD; k++) begin
      pl_r[k] <= $signed(prod_i.a[CA[k]]) * $signed({1'b0, prod_i.t[CT[k]][TL_W-1:0]});
      ph_r[k] <= $signed(prod_i.a[CA[k]]) * $signed(prod_i.t[CT[k]][T_W-1:TL_W]);
    end
    side_r[0].mode <= prod_i.mode;
    side_r[0].v    <= prod_i.v;
    side_r[0].mres <= prod_i.mres;
    for (int k = 0; k < NPROD; k++) begin
      full_r[k] <= (tp_t'(ph_r[k]) <<< TL_W) + tp_t'(pl_r[k]);
    end
    side_r[1] <= side_r[0];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s[i] = (acc_t'($signed(side_r[1].v[i])) <<< FRAC_W)
           + (acc_t'(full_r[i]) <<< 1)
           + ((acc_t'(full_r[3+2*i]) - acc_t'(full_r[4+2*i])) <<< 1);
      rs[i] = sat_word(rnd(s[i]));
    end
    res_nxt = '0;
    unique case (side_r[1].mode)
      MODE_MUL: begin
        res_nxt = side_r[1].mres;
      end
      MODE_ROT: begin
        res_nxt.x         = rs[0].val;
        res_nxt.y         = rs[1].val;
        res_nxt.z         = rs[2].val;
        res_nxt.saturated = rs[0].sat | rs[1].sat | rs[2].sat;
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    mode_r <= side_r[1].mode;
  end

  assign vld_o  = vld_r[2];
  assign mode_o = mode_r;
  assign res_o  = res_r;

endmodule
`default_nettype wire

>>> sv/qalu_div.sv
`default_nettype none
module qalu_div import qalu_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire prod_t prod_i,
  output logic       vld_o,
  output res_t       res_o
);

  typedef struct packed {
    logic [3:0][REM_W-1:0]  rem;
    logic [3:0][WORD_W-1:0] lo;
    logic [DIV_W-1:0]       den;
    logic [3:0]             neg;
    logic [3:0]             ovf;
    logic                   zero;
  } divst_t;

  divst_t st [WORD_W+1];
  logic   sv [WORD_W+1];

  divst_t st0_r;
  divst_t st0_nxt;
  logic   vld0_r;
  logic   [WORD_W:0] ext [4];
  logic   [WORD_W:0] mag [4];
  logic   [DIV_W-1:0] num [4];

  res_t   res_r;
  res_t   res_nxt;
  logic   vld_r;
  word_t  lane [4];
  logic   lsat [4];
  logic   [WORD_W-1:0] q;

  always_comb begin
    st0_nxt.den  = DIV_W'(prod_i.norm) << 1;
    st0_nxt.zero = (prod_i.norm == '0);
    for (int k = 0; k < 4; k++) begin
      ext[k] = {prod_i.a[k][WORD_W-1], prod_i.a[k]};
      mag[k] = ext[k][WORD_W] ? (~ext[k] + (WORD_W+1)'(1)) : ext[k];
      num[k] = (DIV_W'(mag[k]) << (WORD_W + 1)) + DIV_W'(prod_i.norm);
      st0_nxt.rem[k] = REM_W'(num[k][DIV_W-1:WORD_W]);
      st0_nxt.lo[k]  = num[k][WORD_W-1:0];
      st0_nxt.ovf[k] = DIV_W'(num[k][DIV_W-1:WORD_W]) >= st0_nxt.den;
      st0_nxt.neg[k] = prod_i.a[k][WORD_W-1] ^ (k != 0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= prod_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    st0_r <= st0_nxt;
  end

  assign st[0] = st0_r;
  assign sv[0] = vld0_r;

  for (genvar g = 0; g < WORD_W; g++) begin : g_step
    divst_t             st_r;
    divst_t             st_nxt;
    logic               vld_s_r;
    logic [REM_W-1:0]   rsh [4];
    logic [REM_W-1:0]   rdf [4];
    logic               ge [4];

    always_comb begin
      st_nxt = st[g];
      for (int k = 0; k < 4; k++) begin
        rsh[k] = {st[g].rem[k][REM_W-2:0], st[g].lo[k][WORD_W-1]};
        rdf[k] = rsh[k] - REM_W'(st[g].den);
        ge[k]  = rsh[k] >= REM_W'(st[g].den);
        st_nxt.rem[k] = ge[k] ? rdf[k] : rsh[k];
        st_nxt.lo[k]  = {st[g].lo[k][WORD_W-2:0], ge[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_s_r <= 1'b0;
      end else begin
        vld_s_r <= sv[g];
      end
    end

    always_ff @(posedge clk) begin
      st_r <= st_nxt;
    end

    assign st[g+1] = st_r;
    assign sv[g+1] = vld_s_r;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      q = st[WORD_W].lo[k];
      if (st[WORD_W].neg[k]) begin
        if (st[WORD_W].ovf[k] || (q[WORD_W-1] && (|q[WORD_W-2:0]))) begin
          lane[k] = WORD_MIN;
          lsat[k] = 1'b1;
        end else begin
          lane[k] = word_t'(~q + WORD_W'(1));
          lsat[k] = 1'b0;
        end
      end else begin
        if (st[WORD_W].ovf[k] || q[WORD_W-1]) begin
          lane[k] = WORD_MAX;
          lsat[k] = 1'b1;
        end else begin
          lane[k] = word_t'(q);
          lsat[k] = 1'b0;
        end
      end
    end
    if (st[WORD_W].zero) begin
      res_nxt           = '0;
      res_nxt.zero_norm = 1'b1;
    end else begin
      res_nxt.w         = lane[0];
      res_nxt.x         = lane[1];
      res_nxt.y         = lane[2];
      res_nxt.z         = lane[3];
      res_nxt.zero_norm = 1'b0;
      res_nxt.saturated = lsat[0] | lsat[1] | lsat[2] | lsat[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= sv[WORD_W];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign vld_o = vld_r;
  assign res_o = res_r;

endmodule
`default_nettype wire
